// File: hdl/pcfs_pkg.sv
// Package for the per-channel fragment statistics block.
// Holds payload structs, the channel table entry, global totals and FSM states.
// No dependencies.
package pcfs_pkg;

  localparam logic [31:0] SAT32    = 32'hffff_ffff;
  localparam logic [47:0] SAT48    = 48'hffff_ffff_ffff;
  localparam logic [30:0] PKT_NONE = 31'h7fff_ffff;

  typedef struct packed {
    logic [9:0]  channel;
    logic [3:0]  detector_kind;
    logic [31:0] event_id;
    logic [47:0] stamp;
    logic [31:0] run_seconds;
    logic [30:0] packet_number;
    logic [15:0] dead_ticks;
  } in_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [31:0] id_low;
    logic [31:0] id_high;
    logic [47:0] dead_sum;
    logic [47:0] stamp_low;
    logic [47:0] stamp_high;
    logic [31:0] kind_count;
    logic [31:0] packets_seen;
    logic [30:0] packet_low;
    logic [30:0] packet_high;
    logic [31:0] seconds_low;
    logic [31:0] seconds_high;
  } out_t;

  // One word of the channel memory; seen clear means the rest is stale.
  typedef struct packed {
    logic        seen;
    logic [31:0] hits;
    logic [31:0] id_min;
    logic [31:0] id_max;
    logic [47:0] dead;
    logic [47:0] stamp_min;
    logic [47:0] stamp_max;
  } chan_entry_t;

  typedef struct packed {
    logic [31:0] packets;
    logic [30:0] pkt_min;
    logic [30:0] pkt_max;
    logic [31:0] sec_min;
    logic [31:0] sec_max;
  } glob_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } state_t;

endpackage

// File: hdl/pcfs_merge.sv
// Update logic: merges one fragment into the old channel entry, kind count
// and global totals. Purely combinational; uses pcfs_pkg.
module pcfs_merge (
  input  pcfs_pkg::in_t         item,
  input  pcfs_pkg::chan_entry_t ch_old,
  input  logic [31:0]           kind_old,
  input  pcfs_pkg::glob_t       glob_old,
  output pcfs_pkg::chan_entry_t ch_new,
  output logic [31:0]           kind_new,
  output pcfs_pkg::glob_t       glob_new
);
  import pcfs_pkg::*;

  logic [48:0] dead_sum;

  assign dead_sum = {1'b0, ch_old.dead} + 49'(item.dead_ticks);
  assign kind_new = (kind_old == SAT32) ? kind_old : kind_old + 32'd1;

  always_comb begin
    ch_new      = ch_old;
    ch_new.seen = 1'b1;
    if (!ch_old.seen) begin
      // first hit: load the entry from the fragment
      ch_new.hits      = 32'd1;
      ch_new.id_min    = item.event_id;
      ch_new.id_max    = item.event_id;
      ch_new.dead      = 48'(item.dead_ticks);
      ch_new.stamp_min = item.stamp;
      ch_new.stamp_max = item.stamp;
    end else begin
      ch_new.hits = (ch_old.hits == SAT32) ? ch_old.hits : ch_old.hits + 32'd1;
      if (item.event_id < ch_old.id_min) ch_new.id_min = item.event_id;
      if (item.event_id > ch_old.id_max) ch_new.id_max = item.event_id;
      ch_new.dead = dead_sum[48] ? SAT48 : dead_sum[47:0];
      if (item.stamp < ch_old.stamp_min) ch_new.stamp_min = item.stamp;
      if (item.stamp > ch_old.stamp_max) ch_new.stamp_max = item.stamp;
    end
  end

  always_comb begin
    glob_new = glob_old;
    if (item.packet_number != 31'd0) begin
      glob_new.packets = (glob_old.packets == SAT32) ? glob_old.packets
                                                     : glob_old.packets + 32'd1;
      if (item.packet_number < glob_old.pkt_min) glob_new.pkt_min = item.packet_number;
      if (item.packet_number > glob_old.pkt_max) glob_new.pkt_max = item.packet_number;
    end
    // zero bound means unset and takes the incoming second
    if (glob_old.sec_min == 32'd0 || item.run_seconds < glob_old.sec_min) begin
      glob_new.sec_min = item.run_seconds;
    end
    if (glob_old.sec_max == 32'd0 || item.run_seconds > glob_old.sec_max) begin
      glob_new.sec_max = item.run_seconds;
    end
  end

endmodule

// File: hdl/per_channel_fragment_statistics.sv
// The accepted fragment and its entries are registered; the result is registered
// when the update fires, which waits while out_valid is high and out_ready low. A
// new fragment is taken only once the read-modify-write of the channel memory (read
// on accept, write back on update) is done. Reset: synchronous, active low; then a
// clearing pass zeroes both memories with in_ready low.
// Top level of the per-channel fragment statistics; uses pcfs_pkg, pcfs_merge.
module per_channel_fragment_statistics #(
  parameter int CHANNELS       = 1024,
  parameter int DETECTOR_KINDS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pcfs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pcfs_pkg::out_t out_data
);
  import pcfs_pkg::*;

  localparam int CH_AW     = $clog2(CHANNELS);
  localparam int KIND_AW   = (DETECTOR_KINDS > 1) ? $clog2(DETECTOR_KINDS) : 1;
  localparam int CLR_DEPTH = (CHANNELS > DETECTOR_KINDS) ? CHANNELS : DETECTOR_KINDS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  state_t state_r, state_nxt;

  chan_entry_t chan_mem [CHANNELS];
  logic [31:0] kind_mem [DETECTOR_KINDS];

  chan_entry_t chan_q_r;
  logic [31:0] kind_q_r;

  in_t               item_r;
  logic [CH_AW-1:0]  ch_r;
  logic [KIND_AW-1:0] kind_r;

  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  glob_t            glob_r, glob_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;

  logic [9:0]         ch_rem;
  logic [3:0]         kind_rem;
  logic [CH_AW-1:0]   ch_idx;
  logic [KIND_AW-1:0] kind_idx;

  logic        accept;
  logic        calc_fire;
  logic        clr_last;
  chan_entry_t ch_new;
  logic [31:0] kind_new;

  // Reduce the indexes modulo the table sizes by conditional subtraction.
  always_comb begin
    ch_rem = in_data.channel;
    for (int k = 9; k >= 0; k--) begin
      if ((32'(CHANNELS) << k) <= 32'd1023 &&
          {22'd0, ch_rem} >= (32'(CHANNELS) << k)) begin
        ch_rem = ch_rem - 10'(32'(CHANNELS) << k);
      end
    end
    kind_rem = in_data.detector_kind;
    for (int k = 3; k >= 0; k--) begin
      if ((32'(DETECTOR_KINDS) << k) <= 32'd15 &&
          {28'd0, kind_rem} >= (32'(DETECTOR_KINDS) << k)) begin
        kind_rem = kind_rem - 4'(32'(DETECTOR_KINDS) << k);
      end
    end
  end

  assign ch_idx   = CH_AW'(ch_rem);
  assign kind_idx = KIND_AW'(kind_rem);

  assign accept   = in_valid && in_ready;
  assign clr_last = (clr_cnt_r == CLR_W'(CLR_DEPTH - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_CALC;
      ST_CALC:  if (calc_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    calc_fire = 1'b0;
    unique case (state_r)
      ST_CLEAR: ;
      ST_IDLE:  in_ready = 1'b1;
      ST_CALC:  calc_fire = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  pcfs_merge u_merge (
    .item     (item_r),
    .ch_old   (chan_q_r),
    .kind_old (kind_q_r),
    .glob_old (glob_r),
    .ch_new   (ch_new),
    .kind_new (kind_new),
    .glob_new (glob_nxt)
  );

  // Channel memory: clear pass, else read on accept and write back on calc.
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      if (32'(clr_cnt_r) < 32'(CHANNELS)) begin
        chan_mem[clr_cnt_r[CH_AW-1:0]] <= '0;
      end
    end else if (calc_fire) begin
      chan_mem[ch_r] <= ch_new;
    end
    if (accept) begin
      chan_q_r <= chan_mem[ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      if (32'(clr_cnt_r) < 32'(DETECTOR_KINDS)) begin
        kind_mem[clr_cnt_r[KIND_AW-1:0]] <= '0;
      end
    end else if (calc_fire) begin
      kind_mem[kind_r] <= kind_new;
    end
    if (accept) begin
      kind_q_r <= kind_mem[kind_idx];
    end
  end

  // Hold the accepted transaction for the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      ch_r   <= ch_idx;
      kind_r <= kind_idx;
    end
  end

  assign clr_cnt_nxt   = (state_r == ST_CLEAR) ? clr_cnt_r + CLR_W'(1) : clr_cnt_r;
  assign out_valid_nxt = calc_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      glob_r.packets <= '0;
      glob_r.pkt_min <= PKT_NONE;
      glob_r.pkt_max <= '0;
      glob_r.sec_min <= '0;
      glob_r.sec_max <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (calc_fire) begin
        glob_r <= glob_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (calc_fire) begin
      out_data_r.hits         <= ch_new.hits;
      out_data_r.id_low       <= ch_new.id_min;
      out_data_r.id_high      <= ch_new.id_max;
      out_data_r.dead_sum     <= ch_new.dead;
      out_data_r.stamp_low    <= ch_new.stamp_min;
      out_data_r.stamp_high   <= ch_new.stamp_max;
      out_data_r.kind_count   <= kind_new;
      out_data_r.packets_seen <= glob_nxt.packets;
      out_data_r.packet_low   <= glob_nxt.pkt_min;
      out_data_r.packet_high  <= glob_nxt.pkt_max;
      out_data_r.seconds_low  <= glob_nxt.sec_min;
      out_data_r.seconds_high <= glob_nxt.sec_max;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_CALC)
    else $error("accepted transaction did not enter update");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready)
    else $error("input ready during clearing pass");

  a_out_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_CALC))
    else $error("result appeared without an update");

  a_pkt_bounds_unset: assert property (@(posedge clk) disable iff (!rst_n)
    glob_r.packets == 32'd0 |-> glob_r.pkt_min == PKT_NONE && glob_r.pkt_max == 31'd0)
    else $error("packet bounds moved without a counted packet");

  a_sec_max_set: assert property (@(posedge clk) disable iff (!rst_n)
    glob_r.sec_min != 32'd0 |-> glob_r.sec_max != 32'd0)
    else $error("seconds minimum set while maximum unset");
`endif

endmodule
